// ===== rtl/scfla_pkg.sv =====
`timescale 1ns / 1ps

package scfla_pkg;

  // Default configuration
  localparam int NUM_CLASSES_DEF = 16;
  localparam int CHUNK_BYTES_DEF = 40944;
  localparam int WORD_BYTES_DEF  = 8;
  localparam int POOL_BYTES_DEF  = 1048576;

  // Field widths
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 40;  // item_size, elem_address, zero fill
  localparam int OUT_DATA_W = 24;  // address, status, zero fill

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_TABLE_FULL,
    STAT_TOO_LARGE,
    STAT_BAD_SIZE,
    STAT_UNKNOWN_FREE,
    STAT_POOL_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_CLASS,
    ST_MODM,
    ST_MODR,
    ST_ACT,
    ST_POP,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/size_class_free_list_allocator_unit.sv =====
`timescale 1ns / 1ps

// Size-class free-list allocator.
// Slave channel (s_*): one beat is one request. s_tuser carries the kind
// (allocate or free), s_tdata the element size and, for a free, the element
// address. Master channel (m_*): one beat per request with the allocated
// address (zero on a free or on an error) and a status code.
// Requests are handled one at a time by a sequencer: class match against the
// open sizes, two constant-divide steps that turn the address into a link
// word index, then a read-modify-write of the per-class memory and, for a
// free or a pop, the link word memory. A result is loaded into the output
// register in the final step, ST_DONE, which a pop from a freed stack reaches
// through ST_POP; the next request is accepted in the cycle after that, so
// the block does not take a new request before the last one is through.
// When the receiver stalls, the result holds in the output register; a
// further request is still accepted and runs up to its final step, where it
// waits until the output register has been taken.
// Reset clears the class count, the pool pointer, the sequencer and the
// output valid. The class and link memories are not cleared; their contents
// are only used at entries that have been written before.
module size_class_free_list_allocator_unit #(
  parameter int NUM_CLASSES = scfla_pkg::NUM_CLASSES_DEF,
  parameter int CHUNK_BYTES = scfla_pkg::CHUNK_BYTES_DEF,
  parameter int WORD_BYTES  = scfla_pkg::WORD_BYTES_DEF,
  parameter int POOL_BYTES  = scfla_pkg::POOL_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] item_size, [35:16] elem_address, [39:36] zero
  input  logic [scfla_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [19:0] address, [22:20] status, [23] zero
  output logic [scfla_pkg::OUT_DATA_W-1:0] m_tdata
);

  import scfla_pkg::*;

  localparam int CW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W      = $clog2(NUM_CLASSES + 1);
  localparam int PW         = $clog2(POOL_BYTES + 1);
  localparam int PSW        = PW + 1;
  localparam int LINK_DEPTH = POOL_BYTES / WORD_BYTES;
  localparam int LW         = $clog2(LINK_DEPTH);
  localparam int DMW        = ADDR_W + 1;
  localparam int PRW        = ADDR_W + DMW;
  localparam int DIV_SH     = ADDR_W + $clog2(WORD_BYTES);
  localparam int MOD_SH     = ADDR_W + LW;
  localparam logic [DMW-1:0] DIV_MUL = DMW'((64'd1 << DIV_SH) / WORD_BYTES);
  localparam logic [DMW-1:0] MOD_MUL = DMW'((64'd1 << MOD_SH) / LINK_DEPTH);

  typedef struct packed {
    logic              head_valid;
    logic [ADDR_W-1:0] head_addr;
    logic [LW-1:0]     head_widx;
    logic [ADDR_W-1:0] carve_next;
    logic [SIZE_W-1:0] carve_rem;   // bytes left in the current chunk
  } class_entry_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [LW-1:0]     widx;
  } link_entry_t;

  state_t state, state_next;

  // Request
  logic              lat_kind;
  logic [SIZE_W-1:0] lat_size;
  logic [ADDR_W-1:0] lat_addr;

  // Class table
  logic [SIZE_W-1:0]      class_size [NUM_CLASSES];
  logic [CNT_W-1:0]       class_count;
  logic [NUM_CLASSES-1:0] match_next, match_r;
  logic [CW-1:0]          match_idx, cls_sel, cls;
  logic                   found, open_cls, new_cls;
  status_t                status_c, status_r;

  // Constant dividers
  logic [PRW-1:0]    prod_a, prod_s, prod_m;
  logic [ADDR_W-1:0] q0, r0, qa, sq0, sr0, t0, rm0;
  logic              size_mis;
  logic [LW-1:0]     widx;

  // Pool and memories
  logic [PW-1:0]  pool_top;
  class_entry_t   cmem [NUM_CLASSES];
  class_entry_t   crd, entry, cm_wdata;
  logic [CW-1:0]  cm_waddr;
  logic           cm_re, cm_we;
  link_entry_t    lmem [LINK_DEPTH];
  link_entry_t    lrd, lm_wdata;
  logic           lm_re, lm_we;

  // Action step
  logic              is_free, ok, pop, carve, need_chunk, exhaust, carve_go;
  logic [ADDR_W-1:0] carve_addr;
  logic [SIZE_W-1:0] carve_base;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic              slot_free, out_load;

  assign slot_free = !m_tvalid || m_tready;

  // Class match against open sizes
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      match_next[c] = (CNT_W'(c) < class_count) && (class_size[c] == lat_size);
    end
  end

  // Sizes are unique per class, so at most one bit is set
  always_comb begin
    match_idx = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (match_r[c]) begin
        match_idx = match_idx | CW'(c);
      end
    end
  end

  always_comb begin
    found = |match_r;
    q0    = ADDR_W'(prod_a >> DIV_SH);
    r0    = lat_addr - ADDR_W'(q0 * WORD_BYTES);
    sq0   = ADDR_W'(prod_s >> DIV_SH);
    sr0   = ADDR_W'(lat_size) - ADDR_W'(sq0 * WORD_BYTES);
    size_mis = (sr0 != '0) && (sr0 != ADDR_W'(WORD_BYTES));
    t0    = ADDR_W'(prod_m >> MOD_SH);
    rm0   = qa - ADDR_W'(t0 * LINK_DEPTH);
    priority if (found) begin
      status_c = STAT_OK;
    end else if (lat_kind == KIND_FREE) begin
      status_c = STAT_UNKNOWN_FREE;
    end else if (class_count >= CNT_W'(NUM_CLASSES)) begin
      status_c = STAT_TABLE_FULL;
    end else if (32'(lat_size) > CHUNK_BYTES) begin
      status_c = STAT_TOO_LARGE;
    end else if (lat_size == '0 || size_mis) begin
      status_c = STAT_BAD_SIZE;
    end else begin
      status_c = STAT_OK;
    end
    open_cls = !found && (lat_kind == KIND_ALLOC) && (status_c == STAT_OK);
    cls_sel  = found ? match_idx : CW'(class_count);
  end

  // Action decision on the class entry
  always_comb begin
    entry      = new_cls ? '0 : crd;
    is_free    = (lat_kind == KIND_FREE);
    ok         = (status_r == STAT_OK);
    pop        = ok && !is_free && entry.head_valid;
    carve      = ok && !is_free && !entry.head_valid;
    need_chunk = carve && (entry.carve_rem < lat_size);
    exhaust    = need_chunk &&
                 (PSW'(pool_top) + PSW'(CHUNK_BYTES) > PSW'(POOL_BYTES));
    carve_go   = carve && !exhaust;
    carve_addr = need_chunk ? ADDR_W'(pool_top) : entry.carve_next;
    carve_base = need_chunk ? SIZE_W'(CHUNK_BYTES) : entry.carve_rem;

    cm_wdata = entry;
    if (state == ST_POP) begin
      cm_wdata.head_valid = lrd.valid;
      cm_wdata.head_addr  = lrd.addr;
      cm_wdata.head_widx  = lrd.widx;
    end else if (ok && is_free) begin
      cm_wdata.head_valid = 1'b1;
      cm_wdata.head_addr  = lat_addr;
      cm_wdata.head_widx  = widx;
    end else if (carve_go) begin
      cm_wdata.carve_next = ADDR_W'(carve_addr + ADDR_W'(lat_size));
      cm_wdata.carve_rem  = carve_base - lat_size;
    end
    cm_waddr = cls;

    lm_wdata.valid = entry.head_valid;
    lm_wdata.addr  = entry.head_addr;
    lm_wdata.widx  = entry.head_widx;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_CLASS;
      ST_CLASS: state_next = ST_MODM;
      ST_MODM:  state_next = ST_MODR;
      ST_MODR:  state_next = ST_ACT;
      ST_ACT:   state_next = pop ? ST_POP : ST_DONE;
      ST_POP:   state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    cm_re    = (state == ST_CLASS);
    cm_we    = ((state == ST_ACT) && ok && !pop) || (state == ST_POP);
    lm_we    = (state == ST_ACT) && ok && is_free;
    lm_re    = (state == ST_ACT) && pop;
    out_load = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= '0;
      pool_top    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == ST_CLASS && open_cls) begin
        class_count <= class_count + 1'b1;
      end
      if (state == ST_ACT && need_chunk && !exhaust) begin
        pool_top <= PW'(pool_top + PW'(CHUNK_BYTES));
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      lat_kind <= s_tuser;
      lat_size <= s_tdata[SIZE_W-1:0];
      lat_addr <= s_tdata[SIZE_W +: ADDR_W];
    end
    if (state == ST_MATCH) begin
      match_r <= match_next;
      prod_a  <= PRW'(lat_addr) * PRW'(DIV_MUL);
      prod_s  <= PRW'(lat_size) * PRW'(DIV_MUL);
    end
    if (state == ST_CLASS) begin
      // quotient estimate is at most one short
      qa       <= (r0 >= ADDR_W'(WORD_BYTES)) ? ADDR_W'(q0 + 1'b1) : q0;
      cls      <= cls_sel;
      new_cls  <= open_cls;
      status_r <= status_c;
      if (open_cls) begin
        class_size[cls_sel] <= lat_size;
      end
    end
    if (state == ST_MODM) begin
      prod_m <= PRW'(qa) * PRW'(MOD_MUL);
    end
    if (state == ST_MODR) begin
      widx <= (32'(rm0) >= LINK_DEPTH) ? LW'(32'(rm0) - LINK_DEPTH) : LW'(rm0);
    end
    if (state == ST_ACT) begin
      res_status <= exhaust ? STAT_POOL_EMPTY : status_r;
      if (pop) begin
        res_addr <= entry.head_addr;
      end else if (carve_go) begin
        res_addr <= carve_addr;
      end else begin
        res_addr <= '0;
      end
    end
    if (out_load) begin
      m_tdata <= {1'b0, res_status, res_addr};
    end
  end

  // Per-class memory
  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      crd <= cmem[cls_sel];
    end
  end

  // Link word memory
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[widx] <= lm_wdata;
    end
    if (lm_re) begin
      lrd <= lmem[entry.head_widx];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(class_count) <= NUM_CLASSES)
    else $error("class count beyond class limit");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pool_top) <= POOL_BYTES)
    else $error("pool pointer beyond pool size");

  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[ADDR_W +: STATUS_W] != STAT_OK) |-> m_tdata[ADDR_W-1:0] == '0)
    else $error("nonzero address on error result");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside final step");

endmodule
